### hw/rtl/ad_tape_jacobian_sweep_top_assert.svh
// assertion helpers for the rtl files, included by the controller
`ifndef AD_TAPE_JACOBIAN_SWEEP_TOP_ASSERT_SVH
`define AD_TAPE_JACOBIAN_SWEEP_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define AJS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define AJS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/ajs_pkg.sv
package ajs_pkg;

  localparam int LANES_DEF      = 4;
  localparam int MAX_OPS_DEF    = 4096;
  localparam int MAX_STMT_DEF   = 1024;
  localparam int GRAD_SLOTS_DEF = 1024;
  localparam int MAX_VARS_DEF   = 64;

  localparam logic [31:0] FX_ONE = 32'h0001_0000;

  localparam logic [2:0] CMD_LOAD_OP    = 3'd0;
  localparam logic [2:0] CMD_LOAD_STMT  = 3'd1;
  localparam logic [2:0] CMD_LOAD_INDEP = 3'd2;
  localparam logic [2:0] CMD_LOAD_DEP   = 3'd3;
  localparam logic [2:0] CMD_COMPUTE    = 3'd4;

  localparam logic [1:0] REG_STMT_COUNT  = 2'd0;
  localparam logic [1:0] REG_INDEP_COUNT = 2'd1;
  localparam logic [1:0] REG_DEP_COUNT   = 2'd2;
  localparam logic [1:0] REG_DIRECTION   = 2'd3;

  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  localparam logic [1:0] STS_OK             = 2'd0;
  localparam logic [1:0] STS_NOT_IDENTIFIED = 2'd1;
  localparam logic [1:0] STS_OUT_OF_RANGE   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_CLR, S_SD_RD, S_SD_G, S_SD_WR, S_ST_INIT, S_ST_CHK,
    S_ST_RD1, S_ST_RD2, S_TG_CAP, S_OP_CHK, S_OP_G, S_OP_MUL, S_OP_ACC,
    S_FW_WR, S_ST_NX, S_ROW_RD, S_ROW_G, S_ROW_SHOW, S_OUT_WAIT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_START, DP_ERR, DP_CLR, DP_SEED_RD, DP_SEED_G, DP_SEED_WR,
    DP_ST_INIT, DP_ST_RD0, DP_ST_RD1, DP_ST_RD2, DP_TG_CAP, DP_OP_RD, DP_OP_G,
    DP_OP_MUL, DP_OP_ACC, DP_FW_WR, DP_ST_NEXT, DP_ROW_RD, DP_ROW_G, DP_ROW_SHOW
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic rev;
    logic clr_last;
    logic seed_last;
    logic st_done;
    logic op_done;
    logic out_busy;
    logic out_last;
  } dp_status_t;

endpackage

### hw/rtl/ad_tape_jacobian_sweep_top.sv
// jacobian engine over a differentiation tape in q16.16. load commands (op, statement,
// independent, dependent) are accepted while idle and give no result. a compute command
// is checked first; if the check passes, it clears every gradient store entry in a pass,
// seeds the block with a read, a slot fetch and a write per valid lane, then sweeps: a
// setup step, then per statement a check, the reads of its operation bounds, the target
// capture in reverse or the target write in forward, and a step to the next statement,
// with each tape operation worked as an op read, a gradient read, a multiply and an
// accumulate. each result row is then read, fetched and shown, and held while the
// consumer stalls it. an error result is offered in the cycle after the check. one item
// is worked at a time; in_stall is high from the compute transfer until the last row has
// been transferred and the sequencer is back in idle.
module ad_tape_jacobian_sweep_top #(
  parameter int LANES          = ajs_pkg::LANES_DEF,
  parameter int MAX_OPS        = ajs_pkg::MAX_OPS_DEF,
  parameter int MAX_STATEMENTS = ajs_pkg::MAX_STMT_DEF,
  parameter int GRADIENT_SLOTS = ajs_pkg::GRAD_SLOTS_DEF,
  parameter int MAX_VARIABLES  = ajs_pkg::MAX_VARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [10:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [11:0]        in_entry,
  input  logic signed [31:0] in_multiplier,
  input  logic [9:0]         in_slot,
  input  logic [12:0]        in_op_end,
  input  logic [3:0]         in_seed_block,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_reversed,
  output logic [5:0]         out_variable,
  output logic [5:0]         out_first_seed,
  output logic [2:0]         out_lanes_valid,
  output logic signed [31:0] out_value_lane0,
  output logic signed [31:0] out_value_lane1,
  output logic signed [31:0] out_value_lane2,
  output logic signed [31:0] out_value_lane3,
  output logic               out_last
);
  import ajs_pkg::*;

  // one datapath micro-op per cycle from the sequencer
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: accepts a transfer only when idle, steps the sweep
  ajs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .status     (status)
  );

  // datapath: tape stores, gradient memory, per-lane multiply and saturating add
  ajs_dp #(
    .LANES          (LANES),
    .MAX_OPS        (MAX_OPS),
    .MAX_STATEMENTS (MAX_STATEMENTS),
    .GRADIENT_SLOTS (GRADIENT_SLOTS),
    .MAX_VARIABLES  (MAX_VARIABLES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_entry        (in_entry),
    .in_multiplier   (in_multiplier),
    .in_slot         (in_slot),
    .in_op_end       (in_op_end),
    .in_seed_block   (in_seed_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_reversed    (out_reversed),
    .out_variable    (out_variable),
    .out_first_seed  (out_first_seed),
    .out_lanes_valid (out_lanes_valid),
    .out_value_lane0 (out_value_lane0),
    .out_value_lane1 (out_value_lane1),
    .out_value_lane2 (out_value_lane2),
    .out_value_lane3 (out_value_lane3),
    .out_last        (out_last)
  );

endmodule

### hw/rtl/ajs_ctrl.sv
module ajs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_command,
  output logic               in_stall,
  output ajs_pkg::dp_cmd_t   cmd,
  input  ajs_pkg::dp_status_t status
);
  import ajs_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_COMPUTE) begin
            cmd.op    = DP_START;
            state_nxt = S_CHECK;
          end else begin
            cmd.op = DP_LOAD;
          end
        end
      end
      S_CHECK: begin
        if (status.err) begin
          cmd.op    = DP_ERR;
          state_nxt = S_OUT_WAIT;
        end else begin
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.op = DP_CLR;
        if (status.clr_last) state_nxt = S_SD_RD;
      end
      S_SD_RD: begin
        cmd.op    = DP_SEED_RD;
        state_nxt = S_SD_G;
      end
      S_SD_G: begin
        cmd.op    = DP_SEED_G;
        state_nxt = S_SD_WR;
      end
      S_SD_WR: begin
        cmd.op    = DP_SEED_WR;
        state_nxt = status.seed_last ? S_ST_INIT : S_SD_RD;
      end
      S_ST_INIT: begin
        cmd.op    = DP_ST_INIT;
        state_nxt = S_ST_CHK;
      end
      S_ST_CHK: begin
        if (status.st_done) begin
          state_nxt = S_ROW_RD;
        end else begin
          cmd.op    = DP_ST_RD0;
          state_nxt = S_ST_RD1;
        end
      end
      S_ST_RD1: begin
        cmd.op    = DP_ST_RD1;
        state_nxt = S_ST_RD2;
      end
      S_ST_RD2: begin
        cmd.op    = DP_ST_RD2;
        state_nxt = status.rev ? S_TG_CAP : S_OP_CHK;
      end
      S_TG_CAP: begin
        cmd.op    = DP_TG_CAP;
        state_nxt = S_OP_CHK;
      end
      S_OP_CHK: begin
        if (status.op_done) begin
          state_nxt = status.rev ? S_ST_NX : S_FW_WR;
        end else begin
          cmd.op    = DP_OP_RD;
          state_nxt = S_OP_G;
        end
      end
      S_OP_G: begin
        cmd.op    = DP_OP_G;
        state_nxt = S_OP_MUL;
      end
      S_OP_MUL: begin
        cmd.op    = DP_OP_MUL;
        state_nxt = S_OP_ACC;
      end
      S_OP_ACC: begin
        cmd.op    = DP_OP_ACC;
        state_nxt = S_OP_CHK;
      end
      S_FW_WR: begin
        cmd.op    = DP_FW_WR;
        state_nxt = S_ST_NX;
      end
      S_ST_NX: begin
        cmd.op    = DP_ST_NEXT;
        state_nxt = S_ST_CHK;
      end
      S_ROW_RD: begin
        cmd.op    = DP_ROW_RD;
        state_nxt = S_ROW_G;
      end
      S_ROW_G: begin
        cmd.op    = DP_ROW_G;
        state_nxt = S_ROW_SHOW;
      end
      S_ROW_SHOW: begin
        cmd.op    = DP_ROW_SHOW;
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (!status.out_busy) state_nxt = status.out_last ? S_IDLE : S_ROW_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`include "ad_tape_jacobian_sweep_top_assert.svh"

  `AJS_ASSERT_IMP(a_idle_no_result, clk, rst_n, state_r == S_IDLE, !status.out_busy)
  `AJS_ASSERT_IMP(a_acc_has_op, clk, rst_n, state_r == S_OP_ACC, !status.op_done)
  `AJS_ASSERT_NEXT(a_compute_checks, clk, rst_n, state_r == S_IDLE && in_valid && in_command == CMD_COMPUTE, state_r == S_CHECK)

endmodule

### hw/rtl/ajs_dp.sv
module ajs_dp #(
  parameter int LANES          = ajs_pkg::LANES_DEF,
  parameter int MAX_OPS        = ajs_pkg::MAX_OPS_DEF,
  parameter int MAX_STATEMENTS = ajs_pkg::MAX_STMT_DEF,
  parameter int GRADIENT_SLOTS = ajs_pkg::GRAD_SLOTS_DEF,
  parameter int MAX_VARIABLES  = ajs_pkg::MAX_VARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ajs_pkg::dp_cmd_t    cmd,
  output ajs_pkg::dp_status_t status,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [10:0]         cfg_wdata,
  input  logic [2:0]          in_command,
  input  logic [11:0]         in_entry,
  input  logic signed [31:0]  in_multiplier,
  input  logic [9:0]          in_slot,
  input  logic [12:0]         in_op_end,
  input  logic [3:0]          in_seed_block,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic                out_reversed,
  output logic [5:0]          out_variable,
  output logic [5:0]          out_first_seed,
  output logic [2:0]          out_lanes_valid,
  output logic signed [31:0]  out_value_lane0,
  output logic signed [31:0]  out_value_lane1,
  output logic signed [31:0]  out_value_lane2,
  output logic signed [31:0]  out_value_lane3,
  output logic                out_last
);
  import ajs_pkg::*;

  localparam int GW  = $clog2(GRADIENT_SLOTS);
  localparam int OAW = $clog2(MAX_OPS);
  localparam int OCW = $clog2(MAX_OPS + 1);
  localparam int SAW = $clog2(MAX_STATEMENTS);
  localparam int SCW = $clog2(MAX_STATEMENTS + 1);
  localparam int VW  = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
  localparam int CW  = (GW > 7) ? GW : 7;
  localparam int LVW = $clog2(LANES + 1);
  localparam int RW  = LANES * 32;
  localparam int PW  = ((LANES > 4) ? LANES : 4) * 32;

  function automatic logic [GW-1:0] gidx(input logic [9:0] s);
    logic [16:0] e;
    e = 17'(s);
    return e[GW-1:0];
  endfunction

  function automatic logic gok(input logic [9:0] s);
    return 17'(s) < 17'(GRADIENT_SLOTS);
  endfunction

  function automatic logic [OCW-1:0] clamp_ops(input logic [12:0] e);
    return (17'(e) > 17'(MAX_OPS)) ? OCW'(MAX_OPS) : OCW'(e);
  endfunction

  // product to q16.16: floor shift then saturate
  function automatic logic signed [31:0] fx_q(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p >>> 16;
    if (q > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (q < -64'sh8000_0000) return 32'sh8000_0000;
    else return q[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else return s[31:0];
  endfunction

  // config registers
  logic [10:0] stmt_count_r;
  logic [6:0]  indep_count_r, dep_count_r;
  logic [1:0]  dir_r;

  // memories
  logic [41:0]   op_mem    [MAX_OPS];
  logic [22:0]   stmt_mem  [MAX_STATEMENTS];
  logic [9:0]    indep_mem [MAX_VARIABLES];
  logic [9:0]    dep_mem   [MAX_VARIABLES];
  logic [RW-1:0] grad_mem  [GRADIENT_SLOTS];

  logic [41:0]   op_q;
  logic [22:0]   stmt_q;
  logic [9:0]    indep_q, dep_q;
  logic [RW-1:0] grad_q;

  // sweep state
  logic [1:0]     err_r;
  logic           rev_r;
  logic [7:0]     first_r;
  logic [LVW-1:0] valid_r;
  logic [SCW-1:0] nst_r, ist_r;
  logic [6:0]     nrows_r;
  logic [CW-1:0]  cnt_r;
  logic [OCW-1:0] lo_r, hi_r, iop_r;
  logic [9:0]     tgt_r, slot_r, src_r;
  logic signed [31:0] m_r;
  logic signed [31:0] a_r   [LANES];
  logic signed [31:0] acc_r [LANES];
  logic signed [63:0] prod_r[LANES];

  logic           out_valid_r, out_rev_r, out_last_r;
  logic [1:0]     out_status_r;
  logic [5:0]     out_var_r, out_first_r;
  logic [2:0]     out_lanes_r;
  logic [31:0]    out_val_r [4];

  // start-of-compute decode
  logic [6:0] nind_c, ndep_c, nseed_c;
  logic       rev_c;
  logic [7:0] first_c, left_c;
  logic [1:0] err_c;
  logic [LVW-1:0] valid_c;

  always_comb begin
    nind_c  = (indep_count_r > 7'(MAX_VARIABLES)) ? 7'(MAX_VARIABLES) : indep_count_r;
    ndep_c  = (dep_count_r > 7'(MAX_VARIABLES)) ? 7'(MAX_VARIABLES) : dep_count_r;
    if (dir_r == DIR_FORWARD)      rev_c = 1'b0;
    else if (dir_r == DIR_REVERSE) rev_c = 1'b1;
    else                           rev_c = (nind_c > ndep_c);
    nseed_c = rev_c ? ndep_c : nind_c;
    first_c = 8'(in_seed_block) * 8'(LANES);
    left_c  = 8'(nseed_c) - first_c;
    valid_c = (left_c > 8'(LANES)) ? LVW'(LANES) : LVW'(left_c);
    if (nind_c == 7'd0 || ndep_c == 7'd0) err_c = STS_NOT_IDENTIFIED;
    else if (first_c >= 8'(nseed_c))       err_c = STS_OUT_OF_RANGE;
    else                                   err_c = STS_OK;
  end

  // memory addressing
  logic [SCW-1:0] ist_m1;
  logic [SAW-1:0] stmt_ra;
  logic [7:0]     var_a;
  logic [9:0]     var_slot;
  logic           grad_re, grad_we;
  logic [GW-1:0]  grad_ra, grad_wa;
  logic [RW-1:0]  grad_wd;
  logic [16:0]    ent17, ist17, ist_m1_17;

  assign ent17     = 17'(in_entry);
  assign ist_m1    = ist_r - SCW'(1);
  assign ist17     = 17'(ist_r);
  assign ist_m1_17 = 17'(ist_m1);
  assign stmt_ra   = (cmd.op == DP_ST_RD0) ? ist_m1_17[SAW-1:0] : ist17[SAW-1:0];
  assign var_a     = (cmd.op == DP_SEED_RD) ? (first_r + 8'(cnt_r)) : 8'(cnt_r);
  assign var_slot  = (rev_r ^ (cmd.op == DP_ROW_G)) ? dep_q : indep_q;

  always_comb begin
    grad_re = 1'b0;
    grad_ra = '0;
    grad_we = 1'b0;
    grad_wa = '0;
    grad_wd = grad_q;
    case (cmd.op)
      DP_SEED_G, DP_ROW_G: begin
        grad_re = 1'b1;
        grad_ra = gidx(var_slot);
      end
      DP_ST_RD2: begin
        grad_re = 1'b1;
        grad_ra = gidx(stmt_q[22:13]);
      end
      DP_OP_G: begin
        grad_re = 1'b1;
        grad_ra = gidx(op_q[9:0]);
      end
      DP_CLR: begin
        grad_we = 1'b1;
        grad_wa = cnt_r[GW-1:0];
        grad_wd = '0;
      end
      DP_SEED_WR: begin
        grad_we = gok(slot_r);
        grad_wa = gidx(slot_r);
        for (int l = 0; l < LANES; l++)
          if (CW'(l) == cnt_r) grad_wd[l*32 +: 32] = FX_ONE;
      end
      DP_TG_CAP: begin
        grad_we = gok(tgt_r);
        grad_wa = gidx(tgt_r);
        grad_wd = '0;
      end
      DP_OP_ACC: begin
        grad_we = rev_r && gok(src_r);
        grad_wa = gidx(src_r);
        for (int l = 0; l < LANES; l++)
          grad_wd[l*32 +: 32] = sat_add(grad_q[l*32 +: 32], fx_q(prod_r[l]));
      end
      DP_FW_WR: begin
        grad_we = gok(tgt_r);
        grad_wa = gidx(tgt_r);
        for (int l = 0; l < LANES; l++) grad_wd[l*32 +: 32] = acc_r[l];
      end
      default: ;
    endcase
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      case (in_command)
        CMD_LOAD_OP:
          if (ent17 < 17'(MAX_OPS)) op_mem[ent17[OAW-1:0]] <= {in_multiplier, in_slot};
        CMD_LOAD_STMT:
          if (ent17 < 17'(MAX_STATEMENTS)) stmt_mem[ent17[SAW-1:0]] <= {in_slot, in_op_end};
        CMD_LOAD_INDEP:
          if (ent17 < 17'(MAX_VARIABLES)) indep_mem[ent17[VW-1:0]] <= in_slot;
        CMD_LOAD_DEP:
          if (ent17 < 17'(MAX_VARIABLES)) dep_mem[ent17[VW-1:0]] <= in_slot;
        default: ;
      endcase
    end
    op_q    <= op_mem[iop_r[OAW-1:0]];
    stmt_q  <= stmt_mem[stmt_ra];
    indep_q <= indep_mem[var_a[VW-1:0]];
    dep_q   <= dep_mem[var_a[VW-1:0]];
    if (grad_we) grad_mem[grad_wa] <= grad_wd;
    if (grad_re) grad_q <= grad_mem[grad_ra];
  end

  // config registers and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stmt_count_r  <= '0;
      indep_count_r <= '0;
      dep_count_r   <= '0;
      dir_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_STMT_COUNT:  stmt_count_r  <= cfg_wdata;
          REG_INDEP_COUNT: indep_count_r <= cfg_wdata[6:0];
          REG_DEP_COUNT:   dep_count_r   <= cfg_wdata[6:0];
          REG_DIRECTION:   dir_r         <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.op == DP_ERR || cmd.op == DP_ROW_SHOW) out_valid_r <= 1'b1;
    end
  end

  logic row_last;
  assign row_last = (cnt_r == CW'(nrows_r) - CW'(1));

  logic [PW-1:0] row_pad;
  assign row_pad = PW'(grad_q);

  // sweep datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_START: begin
        err_r   <= err_c;
        rev_r   <= rev_c;
        first_r <= first_c;
        valid_r <= valid_c;
        nrows_r <= rev_c ? nind_c : ndep_c;
        nst_r   <= (17'(stmt_count_r) > 17'(MAX_STATEMENTS)) ? SCW'(MAX_STATEMENTS)
                                                             : SCW'(stmt_count_r);
        cnt_r   <= '0;
      end
      DP_ERR: begin
        out_status_r <= err_r;
        out_rev_r    <= 1'b0;
        out_var_r    <= '0;
        out_first_r  <= '0;
        out_lanes_r  <= '0;
        out_last_r   <= 1'b1;
        for (int k = 0; k < 4; k++) out_val_r[k] <= '0;
      end
      DP_CLR: cnt_r <= (cnt_r == CW'(GRADIENT_SLOTS - 1)) ? '0 : cnt_r + CW'(1);
      DP_SEED_G, DP_ROW_G: slot_r <= var_slot;
      DP_SEED_WR: cnt_r <= cnt_r + CW'(1);
      DP_ST_INIT: begin
        cnt_r <= '0;
        if (rev_r) ist_r <= (nst_r == '0) ? '0 : nst_r - SCW'(1);
        else       ist_r <= SCW'(1);
      end
      DP_ST_RD1: lo_r <= clamp_ops(stmt_q[12:0]);
      DP_ST_RD2: begin
        hi_r  <= clamp_ops(stmt_q[12:0]);
        tgt_r <= stmt_q[22:13];
        iop_r <= lo_r;
        for (int l = 0; l < LANES; l++) acc_r[l] <= '0;
      end
      DP_TG_CAP:
        for (int l = 0; l < LANES; l++) a_r[l] <= gok(tgt_r) ? grad_q[l*32 +: 32] : '0;
      DP_OP_G: begin
        m_r   <= op_q[41:10];
        src_r <= op_q[9:0];
      end
      DP_OP_MUL:
        for (int l = 0; l < LANES; l++) begin
          if (rev_r)            prod_r[l] <= m_r * a_r[l];
          else if (gok(src_r))  prod_r[l] <= m_r * $signed(grad_q[l*32 +: 32]);
          else                  prod_r[l] <= '0;
        end
      DP_OP_ACC: begin
        iop_r <= iop_r + OCW'(1);
        for (int l = 0; l < LANES; l++) acc_r[l] <= sat_add(acc_r[l], fx_q(prod_r[l]));
      end
      DP_ST_NEXT: ist_r <= rev_r ? ist_r - SCW'(1) : ist_r + SCW'(1);
      DP_ROW_SHOW: begin
        out_status_r <= STS_OK;
        out_rev_r    <= rev_r;
        out_var_r    <= cnt_r[5:0];
        out_first_r  <= first_r[5:0];
        out_lanes_r  <= 3'(valid_r);
        out_last_r   <= row_last;
        for (int k = 0; k < 4; k++)
          out_val_r[k] <= (gok(slot_r) && LVW'(k) < valid_r && k < LANES)
                          ? row_pad[k*32 +: 32] : '0;
        cnt_r <= cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  assign status.err       = (err_r != STS_OK);
  assign status.rev       = rev_r;
  assign status.clr_last  = (cnt_r == CW'(GRADIENT_SLOTS - 1));
  assign status.seed_last = (cnt_r == CW'(valid_r) - CW'(1));
  assign status.st_done   = rev_r ? (ist_r == '0) : (ist_r >= nst_r);
  assign status.op_done   = (iop_r >= hi_r);
  assign status.out_busy  = out_valid_r;
  assign status.out_last  = out_last_r;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_reversed    = out_rev_r;
  assign out_variable    = out_var_r;
  assign out_first_seed  = out_first_r;
  assign out_lanes_valid = out_lanes_r;
  assign out_value_lane0 = out_val_r[0];
  assign out_value_lane1 = out_val_r[1];
  assign out_value_lane2 = out_val_r[2];
  assign out_value_lane3 = out_val_r[3];
  assign out_last        = out_last_r;

endmodule
